/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the tone burst RTL; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge out of reset.
`define STB_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("stb assertion failed");
// Implication checked at every clock edge out of reset.
`define STB_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stb assertion failed");
`else
`define STB_ASSERT(lbl, prop)
`define STB_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

/* hw/rtl/stb_pkg.sv */
// Package for the tone burst generator: widths, register codes and lookup tables.
`default_nettype none

package stb_pkg;

	// Table resolution and sample precision
	localparam int SINE_ADDR_BITS     = 10;
	localparam int ENVELOPE_ADDR_BITS = 8;
	localparam int SAMPLE_BITS        = 32;

	// Field widths
	localparam int PHASE_W     = 32;
	localparam int RAMP_W      = 16;
	localparam int CNT_W       = 18;
	localparam int OUT_W       = 32;
	localparam int Q30_W       = 31;
	localparam int SINE_IDX_W  = SINE_ADDR_BITS + 1;
	localparam int ENV_IDX_W   = ENVELOPE_ADDR_BITS + 1;
	localparam int SINE_SIZE   = (1 << SINE_ADDR_BITS) + 1;
	localparam int ENV_SIZE    = (1 << ENVELOPE_ADDR_BITS) + 1;
	localparam int MUL_CNT_W   = $clog2(Q30_W + 1);
	localparam int DIV_CNT_W   = $clog2(ENVELOPE_ADDR_BITS + 1);
	localparam int SCALE_SHIFT = SAMPLE_BITS - 1;

	// Configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_STEP  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_STEP = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_LEAD       = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_RISE       = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_HOLD       = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_FALL       = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME      = 3'd6;

	// Register defaults
	localparam logic [PHASE_W-1:0] LEFT_STEP_RST  = 32'd89478485;
	localparam logic [PHASE_W-1:0] RIGHT_STEP_RST = 32'd22369621;
	localparam logic [RAMP_W-1:0]  LEAD_RST       = 16'd7968;
	localparam logic [RAMP_W-1:0]  RISE_RST       = 16'd192;
	localparam logic [RAMP_W-1:0]  HOLD_RST       = 16'd960;
	localparam logic [RAMP_W-1:0]  FALL_RST       = 16'd192;
	localparam logic [CNT_W-1:0]   FRAME_RST      = 18'd17280;

	// Fixed point constants, Q1.30
	localparam logic [Q30_W-1:0] ENV_ONE = Q30_W'(1) << 30;
	localparam logic [OUT_W-1:0] SILENT_SAMPLE = 32'd1;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam int TAYLOR_TERMS = 8;
	localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] =
		'{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272};

	// Job handed to one output channel
	typedef struct packed {
		logic               start;
		logic [PHASE_W-1:0] phase;
		logic [Q30_W-1:0]   env;
	} voice_job_t;

	typedef logic [Q30_W-1:0] sine_tab_t [SINE_SIZE];
	typedef logic [Q30_W-1:0] env_tab_t [ENV_SIZE];

	// sin(pi/2 * k / 2^bits) in Q1.30 by truncated Taylor series, elaboration only
	function automatic logic [Q30_W-1:0] quarter_sine(input longint unsigned k,
		input int unsigned bits);
		longint unsigned theta;
		longint unsigned theta2;
		longint unsigned mag;
		longint          sum;
		logic            sub;
		int              i;
		theta  = (k * HALF_PI_Q30) >> bits;
		theta2 = (theta * theta) >> 30;
		mag    = theta;
		sum    = longint'(theta);
		sub    = 1'b1;
		for (i = 0; i < TAYLOR_TERMS; i++) begin
			mag = (mag * theta2) >> 30;
			mag = mag / TAYLOR_DIV[i];
			if (sub) begin
				sum = sum - longint'(mag);
			end else begin
				sum = sum + longint'(mag);
			end
			sub = !sub;
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > longint'(ENV_ONE)) begin
			sum = longint'(ENV_ONE);
		end
		return Q30_W'(sum);
	endfunction

	function automatic sine_tab_t build_sine_tab();
		sine_tab_t tab;
		int        i;
		for (i = 0; i < SINE_SIZE; i++) begin
			tab[i] = quarter_sine(longint'(i), SINE_ADDR_BITS);
		end
		return tab;
	endfunction

	// sin^2 envelope
	function automatic env_tab_t build_env_tab();
		env_tab_t        tab;
		longint unsigned s;
		int              i;
		for (i = 0; i < ENV_SIZE; i++) begin
			s      = longint'(quarter_sine(longint'(i), ENVELOPE_ADDR_BITS));
			tab[i] = Q30_W'((s * s) >> 30);
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();
	localparam env_tab_t  ENV_TAB  = build_env_tab();

endpackage

`default_nettype wire

/* hw/rtl/stb_in_if.sv */
// Tick channel: one transaction requests one stereo frame.
`default_nettype none

interface stb_in_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink   (input valid, input restart, output ready);
endinterface

`default_nettype wire

/* hw/rtl/stb_out_if.sv */
// Frame channel: one transaction carries one stereo sample pair and its flags.
`default_nettype none

interface stb_out_if;
	import stb_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] left_sample;
	logic signed [OUT_W-1:0] right_sample;
	logic                    in_burst;
	logic                    period_end;

	modport source (output valid, output left_sample, output right_sample,
		output in_burst, output period_end, input ready);
	modport sink   (input valid, input left_sample, input right_sample,
		input in_burst, input period_end, output ready);
endinterface

`default_nettype wire

/* hw/rtl/stereo_tone_burst_generator.sv */
// Top level of the stereo tone burst generator: frame control, envelope and channels.
//
// Usage: each transaction on the tick channel asks for one stereo frame; its
// restart bit clears the period counter, burst counter and both phases before
// that frame is made. Exactly one transaction leaves on the frame channel for
// each tick, in order: two Q1.31 samples (bit 0 always set), in_burst and
// period_end. Registers are to be written through cfg_we/cfg_index/cfg_data
// only while the block is idle; the block itself does not enforce this.
// Indexes beyond the register list are ignored. Frame time depends on the
// region: outside the burst window no arithmetic runs; the hold runs the
// envelope multiply; an attack whose index has saturated adds the envelope
// lookup; the attack or release ramps first run the ramp index division.
// The work is set by the 31-step serial envelope multiplier in each channel
// and the 8-step serial divider that forms the ramp index; one frame is in
// work at a time, so no tick is taken until it is in the output register.
// Reset loads the register defaults and clears all counters and phases.
// A finished frame waits in the output register; the next tick is accepted
// meanwhile, and its result is held back until the receiver takes the first.
`default_nettype none
`include "assert_macros.svh"

module stereo_tone_burst_generator (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [stb_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [stb_pkg::CFG_DATA_W-1:0]      cfg_data,
	stb_in_if.sink                                   tick,
	stb_out_if.source                                frame
);
	import stb_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_EVAL  = 7'b0000010,
		S_DIV   = 7'b0000100,
		S_ENV   = 7'b0001000,
		S_START = 7'b0010000,
		S_VOICE = 7'b0100000,
		S_FIN   = 7'b1000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [PHASE_W-1:0] left_step_q;
	logic [PHASE_W-1:0] right_step_q;
	logic [RAMP_W-1:0]  lead_q;
	logic [RAMP_W-1:0]  rise_q;
	logic [RAMP_W-1:0]  hold_q;
	logic [RAMP_W-1:0]  fall_q;
	logic [CNT_W-1:0]   frame_len_q;

	// generator state
	logic [CNT_W-1:0]   period_q;
	logic [CNT_W-1:0]   burst_q;
	logic [PHASE_W-1:0] left_phase_q;
	logic [PHASE_W-1:0] right_phase_q;

	// per-frame working registers
	logic               inside_q;
	logic               last_q;
	logic [ENV_IDX_W-1:0] eidx_q;
	logic [Q30_W-1:0]   env_q;
	logic [1:0]         vdone_q;

	// output register
	logic               out_valid_q;
	logic [OUT_W-1:0]   out_left_q;
	logic [OUT_W-1:0]   out_right_q;
	logic               out_burst_q;
	logic               out_end_q;

	// window decode
	logic [CNT_W-1:0]   rise_end;
	logic [CNT_W-1:0]   hold_end;
	logic [CNT_W-1:0]   win_end;
	logic [CNT_W-1:0]   last_idx;
	logic [CNT_W-1:0]   rel_off;
	logic [RAMP_W-1:0]  rel_n;
	logic               in_window;
	logic               attack;
	logic               release_ph;
	logic               is_last;
	logic               atk_sat;

	logic               tick_acc;
	logic               out_free;
	logic               div_start;
	logic [RAMP_W-1:0]  div_num;
	logic [RAMP_W-1:0]  div_den;
	logic               div_done;
	logic [ENVELOPE_ADDR_BITS-1:0] div_quot;

	voice_job_t         l_job;
	voice_job_t         r_job;
	logic               l_done;
	logic               r_done;
	logic [OUT_W-1:0]   l_sample;
	logic [OUT_W-1:0]   r_sample;
	logic [1:0]         vdone_now;

	assign tick.ready = (state_q == S_IDLE);
	assign tick_acc   = tick.valid && tick.ready;
	assign out_free   = !out_valid_q || frame.ready;

	// burst window boundaries and the region of the current sample
	always_comb begin
		rise_end   = CNT_W'(lead_q) + CNT_W'(rise_q);
		hold_end   = rise_end + CNT_W'(hold_q);
		win_end    = hold_end + CNT_W'(fall_q);
		last_idx   = (frame_len_q == '0) ? '0 : frame_len_q - 1'b1;
		in_window  = (period_q > CNT_W'(lead_q)) && (period_q < win_end);
		attack     = period_q < rise_end;
		release_ph = period_q > hold_end;
		is_last    = period_q >= last_idx;
		atk_sat    = burst_q >= CNT_W'(rise_q);
		rel_off    = period_q - hold_end;
		rel_n      = fall_q - rel_off[RAMP_W-1:0];
	end

	// ramp index division
	always_comb begin
		div_start = (state_q == S_EVAL) && in_window &&
		            ((attack && !atk_sat) || (!attack && release_ph));
		div_num   = attack ? burst_q[RAMP_W-1:0] : rel_n;
		div_den   = attack ? rise_q : fall_q;
	end

	stb_div_serial u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// channel jobs
	always_comb begin
		l_job.start = (state_q == S_START);
		l_job.phase = left_phase_q;
		l_job.env   = env_q;
		r_job.start = (state_q == S_START);
		r_job.phase = right_phase_q;
		r_job.env   = env_q;
		vdone_now   = vdone_q | {r_done, l_done};
	end

	stb_voice u_left (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (l_job),
		.done   (l_done),
		.sample (l_sample)
	);

	stb_voice u_right (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (r_job),
		.done   (r_done),
		.sample (r_sample)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_step_q  <= LEFT_STEP_RST;
			right_step_q <= RIGHT_STEP_RST;
			lead_q       <= LEAD_RST;
			rise_q       <= RISE_RST;
			hold_q       <= HOLD_RST;
			fall_q       <= FALL_RST;
			frame_len_q  <= FRAME_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LEFT_STEP:  left_step_q  <= cfg_data[PHASE_W-1:0];
				CFG_RIGHT_STEP: right_step_q <= cfg_data[PHASE_W-1:0];
				CFG_LEAD:       lead_q       <= cfg_data[RAMP_W-1:0];
				CFG_RISE:       rise_q       <= cfg_data[RAMP_W-1:0];
				CFG_HOLD:       hold_q       <= cfg_data[RAMP_W-1:0];
				CFG_FALL:       fall_q       <= cfg_data[RAMP_W-1:0];
				CFG_FRAME:      frame_len_q  <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// frame sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vdone_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (tick_acc) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (!in_window) begin
						state_q <= S_FIN;
					end else if (div_start) begin
						state_q <= S_DIV;
					end else if (attack) begin
						state_q <= S_ENV;
					end else begin
						state_q <= S_START;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_ENV;
					end
				end
				S_ENV: begin
					state_q <= S_START;
				end
				S_START: begin
					vdone_q <= '0;
					state_q <= S_VOICE;
				end
				S_VOICE: begin
					vdone_q <= vdone_now;
					if (vdone_now == 2'b11) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// frame flags and envelope value
	always_ff @(posedge clk) begin
		if (state_q == S_EVAL) begin
			inside_q <= in_window;
			last_q   <= is_last;
			if (attack) begin
				eidx_q <= ENV_IDX_W'(1) << ENVELOPE_ADDR_BITS;
			end
			env_q <= ENV_ONE;
		end
		if (state_q == S_DIV && div_done) begin
			eidx_q <= {1'b0, div_quot};
		end
		if (state_q == S_ENV) begin
			env_q <= ENV_TAB[eidx_q];
		end
	end

	// counters and phase accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q      <= '0;
			burst_q       <= '0;
			left_phase_q  <= '0;
			right_phase_q <= '0;
		end else if (tick_acc && tick.restart) begin
			period_q      <= '0;
			burst_q       <= '0;
			left_phase_q  <= '0;
			right_phase_q <= '0;
		end else if (state_q == S_FIN && out_free) begin
			if (last_q) begin
				period_q      <= '0;
				burst_q       <= '0;
				left_phase_q  <= '0;
				right_phase_q <= '0;
			end else begin
				period_q <= period_q + 1'b1;
				if (inside_q) begin
					burst_q       <= burst_q + 1'b1;
					left_phase_q  <= left_phase_q + left_step_q;
					right_phase_q <= right_phase_q + right_step_q;
				end
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (frame.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			out_left_q  <= inside_q ? l_sample : SILENT_SAMPLE;
			out_right_q <= inside_q ? r_sample : SILENT_SAMPLE;
			out_burst_q <= inside_q;
			out_end_q   <= last_q;
		end
	end

	assign frame.valid        = out_valid_q;
	assign frame.left_sample  = out_left_q;
	assign frame.right_sample = out_right_q;
	assign frame.in_burst     = out_burst_q;
	assign frame.period_end   = out_end_q;

	// both channels run the same schedule
	`STB_ASSERT(a_voice_lockstep, l_done == r_done)
	// every delivered sample carries the dither bit
	`STB_ASSERT_IMP(a_lsb_set, frame.valid, frame.left_sample[0] && frame.right_sample[0])
	// frames outside the window are silent
	`STB_ASSERT_IMP(a_silent_outside, frame.valid && !frame.in_burst,
		frame.left_sample == SILENT_SAMPLE && frame.right_sample == SILENT_SAMPLE)
	// a new result only comes from the finishing step
	`STB_ASSERT_IMP(a_load_from_fin, $rose(frame.valid), $past(state_q == S_FIN))

endmodule

`default_nettype wire

/* hw/rtl/stb_div_serial.sv */
// Restoring divider, one quotient bit per cycle, for a numerator below the divisor.
`default_nettype none

module stb_div_serial (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	input  wire logic [stb_pkg::RAMP_W-1:0]             num,
	input  wire logic [stb_pkg::RAMP_W-1:0]             den,
	output logic                                        done,
	output logic [stb_pkg::ENVELOPE_ADDR_BITS-1:0]      quot
);
	import stb_pkg::*;

	logic                          busy_q;
	logic                          done_q;
	logic [DIV_CNT_W-1:0]          cnt_q;
	logic [RAMP_W-1:0]             rem_q;
	logic [RAMP_W-1:0]             den_q;
	logic [ENVELOPE_ADDR_BITS-1:0] quot_q;

	logic [RAMP_W:0] shifted;
	logic [RAMP_W:0] diff;
	logic            ge;

	// one trial subtract per cycle
	always_comb begin
		shifted = {rem_q, 1'b0};
		diff    = shifted - {1'b0, den_q};
		ge      = shifted >= {1'b0, den_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(ENVELOPE_ADDR_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[RAMP_W-1:0] : shifted[RAMP_W-1:0];
			quot_q <= {quot_q[ENVELOPE_ADDR_BITS-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

/* hw/rtl/stb_mul_serial.sv */
// Shift-and-add multiplier, one multiplier bit per cycle, Q1.30 by Q1.30.
`default_nettype none

module stb_mul_serial (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [stb_pkg::Q30_W-1:0]      a,
	input  wire logic [stb_pkg::Q30_W-1:0]      b,
	output logic                                done,
	output logic [2*stb_pkg::Q30_W-1:0]         product
);
	import stb_pkg::*;

	logic                   busy_q;
	logic                   done_q;
	logic [MUL_CNT_W-1:0]   cnt_q;
	logic [Q30_W-1:0]       a_q;
	logic [2*Q30_W-1:0]     prod_q;
	logic [Q30_W:0]         sum;

	// add the multiplicand into the upper half when the current bit is set
	always_comb begin
		sum = {1'b0, prod_q[2*Q30_W-1:Q30_W]} + (prod_q[0] ? {1'b0, a_q} : '0);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= MUL_CNT_W'(Q30_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == MUL_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// product shifts right as multiplier bits are consumed
	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			prod_q <= {{Q30_W{1'b0}}, b};
		end else if (busy_q) begin
			prod_q <= {sum, prod_q[Q30_W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = prod_q;

endmodule

`default_nettype wire

/* hw/rtl/stb_voice.sv */
// One output channel: sine lookup, envelope multiply, full-scale scaling and sign.
`default_nettype none

module stb_voice (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire stb_pkg::voice_job_t           job,
	output logic                               done,
	output logic [stb_pkg::OUT_W-1:0]          sample
);
	import stb_pkg::*;

	typedef enum logic [4:0] {
		V_IDLE  = 5'b00001,
		V_LOAD  = 5'b00010,
		V_MUL   = 5'b00100,
		V_SCALE = 5'b01000,
		V_SIGN  = 5'b10000
	} vstate_t;

	vstate_t state_q;
	logic    done_q;

	logic [SINE_ADDR_BITS-1:0] idx;
	logic [SINE_IDX_W-1:0]     addr;
	logic [Q30_W-1:0]          sine_q;
	logic [Q30_W-1:0]          env_q;
	logic                      neg_q;
	logic [OUT_W-1:0]          m_q;
	logic [OUT_W-1:0]          mag_q;
	logic [OUT_W-1:0]          sample_q;

	logic                 mul_start;
	logic                 mul_done;
	logic [2*Q30_W-1:0]   mul_prod;
	logic [63:0]          m_wide;
	logic [63:0]          scaled;

	// quadrant fold of the phase into a quarter-wave address
	always_comb begin
		idx  = job.phase[PHASE_W-3 -: SINE_ADDR_BITS];
		addr = job.phase[PHASE_W-2] ? ((SINE_IDX_W'(1) << SINE_ADDR_BITS) - {1'b0, idx})
		                            : {1'b0, idx};
	end

	// times (2^(SAMPLE_BITS-1) - 1), kept as shift and subtract
	always_comb begin
		m_wide = {32'd0, m_q};
		scaled = (m_wide << SCALE_SHIFT) - m_wide;
	end

	assign mul_start = (state_q == V_LOAD);

	stb_mul_serial u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (sine_q),
		.b       (env_q),
		.done    (mul_done),
		.product (mul_prod)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= V_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				V_IDLE: begin
					if (job.start) begin
						state_q <= V_LOAD;
					end
				end
				V_LOAD: begin
					state_q <= V_MUL;
				end
				V_MUL: begin
					if (mul_done) begin
						state_q <= V_SCALE;
					end
				end
				V_SCALE: begin
					state_q <= V_SIGN;
				end
				V_SIGN: begin
					done_q  <= 1'b1;
					state_q <= V_IDLE;
				end
				default: begin
					state_q <= V_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == V_IDLE && job.start) begin
			sine_q <= SINE_TAB[addr];
			env_q  <= job.env;
			neg_q  <= job.phase[PHASE_W-1];
		end
		if (state_q == V_MUL && mul_done) begin
			m_q <= mul_prod[29 +: OUT_W];
		end
		if (state_q == V_SCALE) begin
			mag_q <= scaled[31 +: OUT_W];
		end
		if (state_q == V_SIGN) begin
			sample_q <= (neg_q ? (OUT_W'(0) - mag_q) : mag_q) | SILENT_SAMPLE;
		end
	end

	assign done   = done_q;
	assign sample = sample_q;

endmodule

`default_nettype wire

/* tb/stereo_tone_burst_generator_tb.sv */
// Self-checking bench for the tone burst generator: directed windows, random bursts, steady stream.

module stereo_tone_burst_generator_tb;
	import stb_pkg::*;

	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned SETTLE_CYCLES = 64;
	localparam int unsigned RANDOM_TICKS  = 750;
	localparam int unsigned STEADY_TICKS  = 100;

	// Q1.30 arithmetic for the tables
	localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
	localparam longint unsigned UNITY_Q30        = 64'd1 << 30;
	localparam int unsigned     SINE_ENTRIES     = (1 << SINE_ADDR_BITS) + 1;
	localparam int unsigned     GAIN_ENTRIES     = (1 << ENVELOPE_ADDR_BITS) + 1;

	typedef longint unsigned u64_t;

	typedef struct {
		logic [OUT_W-1:0] left;
		logic [OUT_W-1:0] right;
		logic             in_burst;
		logic             period_end;
	} stereo_frame_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	stb_in_if  tick();
	stb_out_if frame();

	// Register copies and generator state
	logic [PHASE_W-1:0] step_l;
	logic [PHASE_W-1:0] step_r;
	logic [RAMP_W-1:0]  lead_len;
	logic [RAMP_W-1:0]  rise_len;
	logic [RAMP_W-1:0]  hold_len;
	logic [RAMP_W-1:0]  fall_len;
	logic [CNT_W-1:0]   period_len;
	logic [CNT_W-1:0]   sample_pos;
	logic [CNT_W-1:0]   burst_pos;
	logic [PHASE_W-1:0] acc_l;
	logic [PHASE_W-1:0] acc_r;

	u64_t          quarter_wave [SINE_ENTRIES];
	u64_t          ramp_gain [GAIN_ENTRIES];
	stereo_frame_t frames_due [$];

	int unsigned err_count    = 0;
	int unsigned cycle_count  = 0;
	int unsigned random_ticks = 0;
	bit          bursty       = 1'b1;

	stereo_tone_burst_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tick      (tick),
		.frame     (frame)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// sin(pi/2 * k / 2^bits), truncated Taylor series through the 17th power
	function automatic u64_t taylor_quarter(u64_t k, int unsigned bits);
		u64_t        theta;
		u64_t        theta_sq;
		u64_t        term;
		longint      total;
		int unsigned n;
		theta    = (k * QUARTER_TURN_Q30) >> bits;
		theta_sq = (theta * theta) >> 30;
		term     = theta;
		total    = longint'(theta);
		for (n = 3; n <= 17; n += 2) begin
			term = ((term * theta_sq) >> 30) / (n * (n - 1));
			if (n % 4 == 3) begin
				total -= longint'(term);
			end else begin
				total += longint'(term);
			end
		end
		if (total < 0) begin
			total = 0;
		end
		if (total > longint'(UNITY_Q30)) begin
			total = longint'(UNITY_Q30);
		end
		return u64_t'(total);
	endfunction

	function automatic void build_tables();
		u64_t        s;
		int unsigned i;
		for (i = 0; i < SINE_ENTRIES; i++) begin
			quarter_wave[i] = taylor_quarter(i, SINE_ADDR_BITS);
		end
		for (i = 0; i < GAIN_ENTRIES; i++) begin
			s            = taylor_quarter(i, ENVELOPE_ADDR_BITS);
			ramp_gain[i] = (s * s) >> 30;
		end
	endfunction

	function automatic void load_defaults();
		step_l     = LEFT_STEP_RST;
		step_r     = RIGHT_STEP_RST;
		lead_len   = LEAD_RST;
		rise_len   = RISE_RST;
		hold_len   = HOLD_RST;
		fall_len   = FALL_RST;
		period_len = FRAME_RST;
		sample_pos = '0;
		burst_pos  = '0;
		acc_l      = '0;
		acc_r      = '0;
	endfunction

	function automatic void apply_reg(logic [CFG_INDEX_W-1:0] index,
		logic [CFG_DATA_W-1:0] data);
		case (index)
			CFG_LEFT_STEP:  step_l     = data;
			CFG_RIGHT_STEP: step_r     = data;
			CFG_LEAD:       lead_len   = data[RAMP_W-1:0];
			CFG_RISE:       rise_len   = data[RAMP_W-1:0];
			CFG_HOLD:       hold_len   = data[RAMP_W-1:0];
			CFG_FALL:       fall_len   = data[RAMP_W-1:0];
			CFG_FRAME:      period_len = data[CNT_W-1:0];
			default: ;
		endcase
	endfunction

	// Quarter-wave lookup, mirrored and negated by quadrant, scaled and dithered
	function automatic logic [OUT_W-1:0] tone_sample(logic [PHASE_W-1:0] phase, u64_t gain);
		logic [1:0]       quad;
		int unsigned      k;
		u64_t             full_scale;
		u64_t             scaled;
		u64_t             mag;
		logic [OUT_W-1:0] v;
		quad = phase[PHASE_W-1 -: 2];
		k    = phase[PHASE_W-3 -: SINE_ADDR_BITS];
		if (quad[0]) begin
			k = (1 << SINE_ADDR_BITS) - k;
		end
		full_scale = (u64_t'(1) << (SAMPLE_BITS - 1)) - 1;
		scaled     = (quarter_wave[k] * gain) >> 29;
		mag        = (scaled * full_scale) >> 31;
		v          = mag[OUT_W-1:0];
		if (quad[1]) begin
			v = -v;
		end
		return v | 32'd1;
	endfunction

	// Next stereo frame for one accepted tick; queues it and steps the state
	function automatic void advance_generator(logic restart_bit);
		stereo_frame_t f;
		int unsigned   t;
		int unsigned   rise_end;
		int unsigned   hold_end;
		int unsigned   win_end;
		int unsigned   last;
		int unsigned   n;
		u64_t          idx;
		u64_t          gain;
		if (restart_bit) begin
			sample_pos = '0;
			burst_pos  = '0;
			acc_l      = '0;
			acc_r      = '0;
		end
		t            = sample_pos;
		rise_end     = lead_len + rise_len;
		hold_end     = rise_end + hold_len;
		win_end      = hold_end + fall_len;
		last         = (period_len == 0) ? 0 : period_len - 1;
		f.in_burst   = (t > lead_len) && (t < win_end);
		f.period_end = (t >= last);
		f.left       = SILENT_SAMPLE;
		f.right      = SILENT_SAMPLE;
		if (f.in_burst) begin
			if (t < rise_end) begin
				// attack, index saturates when the burst count overran the ramp
				idx = burst_pos;
				idx = (idx << ENVELOPE_ADDR_BITS) / rise_len;
				if (idx > (1 << ENVELOPE_ADDR_BITS)) begin
					idx = 1 << ENVELOPE_ADDR_BITS;
				end
				gain = ramp_gain[idx];
			end else if (t > hold_end) begin
				n    = fall_len - (t - hold_end);
				idx  = n;
				idx  = (idx << ENVELOPE_ADDR_BITS) / fall_len;
				gain = ramp_gain[idx];
			end else begin
				gain = UNITY_Q30;
			end
			f.left    = tone_sample(acc_l, gain);
			f.right   = tone_sample(acc_r, gain);
			burst_pos = burst_pos + 1'b1;
			acc_l     = acc_l + step_l;
			acc_r     = acc_r + step_r;
		end
		if (f.period_end) begin
			sample_pos = '0;
			burst_pos  = '0;
			acc_l      = '0;
			acc_r      = '0;
		end else begin
			sample_pos = sample_pos + 1'b1;
		end
		frames_due.push_back(f);
	endfunction

	function automatic void check_field(string name, logic [OUT_W-1:0] want,
		logic [OUT_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			err_count++;
		end
	endfunction

	// Frame monitor: every accepted frame against the oldest one due
	always @(posedge clk) begin : check_frames
		stereo_frame_t due;
		if (arst_n && frame.valid && frame.ready) begin
			if (frames_due.size() == 0) begin
				$error("frame transaction arrived with no frame due");
				err_count++;
			end else begin
				due = frames_due.pop_front();
				check_field("left_sample", due.left, frame.left_sample);
				check_field("right_sample", due.right, frame.right_sample);
				check_field("in_burst", due.in_burst, frame.in_burst);
				check_field("period_end", due.period_end, frame.period_end);
			end
		end
	end

	// Receiver: random stall bursts while bursty is set
	initial begin
		frame.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (bursty && $urandom_range(0, 7) == 0) begin
				frame.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			frame.ready <= 1'b1;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$error("no completion within %0d cycles", CYCLE_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// One tick transaction; valid stays up when the next tick follows at once
	task automatic send_tick(input logic restart_bit);
		if (bursty && $urandom_range(0, 3) == 0) begin
			tick.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		tick.valid   <= 1'b1;
		tick.restart <= restart_bit;
		do @(posedge clk); while (tick.ready !== 1'b1);
		advance_generator(restart_bit);
	endtask

	task automatic wait_drained();
		tick.valid <= 1'b0;
		while (frames_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
		input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		apply_reg(index, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly short spans so windows come often, now and then the full width
	function automatic int unsigned short_or_wide(int unsigned short_max, int unsigned width);
		case ($urandom_range(0, 19))
			0:       return (1 << width) - 1;
			1:       return $urandom & ((1 << width) - 1);
			default: return $urandom_range(0, short_max);
		endcase
	endfunction

	function automatic logic [PHASE_W-1:0] random_step();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return 32'h4000_0000;
			3:       return $urandom_range(1, 1 << 24);
			default: return $urandom;
		endcase
	endfunction

	// Junk above the register width must be dropped
	function automatic logic [CFG_DATA_W-1:0] with_spare_bits(int unsigned value,
		int unsigned width);
		logic [CFG_DATA_W-1:0] v;
		v = value;
		if ($urandom_range(0, 3) == 0) begin
			v = v | ($urandom << width);
		end
		return v;
	endfunction

	task automatic pick_random_settings();
		int unsigned lead;
		int unsigned rise;
		int unsigned hold;
		int unsigned fall;
		int unsigned span;
		int unsigned frame_len;
		lead = short_or_wide(12, RAMP_W);
		rise = short_or_wide(12, RAMP_W);
		hold = short_or_wide(12, RAMP_W);
		fall = short_or_wide(12, RAMP_W);
		span = lead + rise + hold + fall;
		case ($urandom_range(0, 19))
			0:       frame_len = 0;
			1:       frame_len = 1;
			2:       frame_len = (1 << CNT_W) - 1;
			3:       frame_len = $urandom & ((1 << CNT_W) - 1);
			default: frame_len = $urandom_range(span / 2, span + 10) & ((1 << CNT_W) - 1);
		endcase
		write_reg(CFG_LEFT_STEP, random_step());
		write_reg(CFG_RIGHT_STEP, random_step());
		write_reg(CFG_LEAD, with_spare_bits(lead, RAMP_W));
		write_reg(CFG_RISE, with_spare_bits(rise, RAMP_W));
		write_reg(CFG_HOLD, with_spare_bits(hold, RAMP_W));
		write_reg(CFG_FALL, with_spare_bits(fall, RAMP_W));
		write_reg(CFG_FRAME, with_spare_bits(frame_len, CNT_W));
		if ($urandom_range(0, 3) == 0) begin
			write_reg(CFG_UNUSED, $urandom);
		end
	endtask

	// Reset defaults: window far away, so silence
	task automatic test_defaults();
		send_tick(1'b1);
		send_tick(1'b0);
		wait_drained();
	endtask

	// One short period: lead edge, attack, hold, release, far edge, wrap;
	// left steps a quarter turn per sample to hit every quadrant
	task automatic test_window_shape();
		int unsigned i;
		write_reg(CFG_UNUSED, 32'h0000_0001);
		write_reg(CFG_LEFT_STEP, 32'h4000_0000);
		write_reg(CFG_RIGHT_STEP, 32'hFFFF_FFFF);
		write_reg(CFG_LEAD, 32'd1);
		write_reg(CFG_RISE, 32'd3);
		write_reg(CFG_HOLD, 32'd1);
		write_reg(CFG_FALL, 32'd3);
		write_reg(CFG_FRAME, 32'd11);
		send_tick(1'b1);
		for (i = 1; i < 11; i++) begin
			send_tick(1'b0);
		end
		wait_drained();
	endtask

	// Move the window back over a burst count that is already past the ramp
	task automatic test_attack_overrun();
		repeat (5) send_tick(1'b0);
		wait_drained();
		write_reg(CFG_LEAD, 32'd4);
		write_reg(CFG_RISE, 32'd2);
		send_tick(1'b0);
		send_tick(1'b0);
		wait_drained();
	endtask

	// Period shrunk under the counter, zero length, and a single sample
	task automatic test_period_limits();
		write_reg(CFG_FRAME, 32'd5);
		send_tick(1'b0);
		wait_drained();
		write_reg(CFG_FRAME, 32'd0);
		send_tick(1'b0);
		send_tick(1'b0);
		wait_drained();
		write_reg(CFG_FRAME, 32'd1);
		send_tick(1'b0);
		wait_drained();
	endtask

	// No attack and no release: only the hold region is left
	task automatic test_empty_ramps();
		write_reg(CFG_LEAD, 32'd0);
		write_reg(CFG_RISE, 32'd0);
		write_reg(CFG_HOLD, 32'd2);
		write_reg(CFG_FALL, 32'd0);
		write_reg(CFG_FRAME, 32'd5);
		send_tick(1'b1);
		repeat (4) send_tick(1'b0);
		wait_drained();
	endtask

	// All ones into every register, upper bits dropped by width
	task automatic test_register_extremes();
		write_reg(CFG_LEFT_STEP, '1);
		write_reg(CFG_RIGHT_STEP, '1);
		write_reg(CFG_LEAD, '1);
		write_reg(CFG_RISE, '1);
		write_reg(CFG_HOLD, '1);
		write_reg(CFG_FALL, '1);
		write_reg(CFG_FRAME, '1);
		send_tick(1'b1);
		send_tick(1'b0);
		wait_drained();
	endtask

	// Random settings, with periods running on across setting changes
	task automatic test_random_bursts();
		while (random_ticks < RANDOM_TICKS) begin
			pick_random_settings();
			repeat ($urandom_range(20, 80)) begin
				send_tick($urandom_range(0, 15) == 0);
				random_ticks++;
			end
			wait_drained();
		end
	endtask

	// Back-to-back ticks and an always-ready receiver
	task automatic test_steady_stream();
		bursty = 1'b0;
		pick_random_settings();
		repeat (STEADY_TICKS) send_tick($urandom_range(0, 15) == 0);
		wait_drained();
	endtask

	initial begin
		build_tables();
		load_defaults();
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_index    <= '0;
		cfg_data     <= '0;
		tick.valid   <= 1'b0;
		tick.restart <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults();
		test_window_shape();
		test_attack_overrun();
		test_period_limits();
		test_empty_ramps();
		test_register_extremes();
		test_random_bursts();
		test_steady_stream();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
